>>> hdl/ipcidr_pkg.sv
`timescale 1ns / 1ps
// ipcidr_pkg: request types and control structs for the range-to-CIDR block.
// No dependencies; imported by every module of the block.
package ipcidr_pkg;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned PLEN_W  = 6;

	typedef struct packed {
		logic [FIELD_W-1:0] range_start;
		logic [FIELD_W-1:0] range_end;
	} range_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] block_base;
		logic [PLEN_W-1:0]  block_prefix_len;
		logic               is_last;
		logic               range_error;
	} block_req_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic emit;
	} ipcidr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
	} ipcidr_stat_t;

endpackage

>>> hdl/ipcidr_ctrl.sv
`timescale 1ns / 1ps
// ipcidr_ctrl: sequencer for the range-to-CIDR block and output valid flag.
// Depends on ipcidr_pkg.
module ipcidr_ctrl
	import ipcidr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         range_valid,
	output logic         range_ready,
	output logic         block_valid,
	input  logic         block_ready,
	output ipcidr_cmd_t  cmd,
	input  ipcidr_stat_t stat
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign range_ready = (state_q == ST_IDLE);
	assign block_valid = out_valid_q;

	always_comb begin
		cmd.load = range_valid && (state_q == ST_IDLE);
		cmd.emit = (state_q == ST_RUN) && (!out_valid_q || block_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (block_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.emit && stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/ipcidr_dp.sv
`timescale 1ns / 1ps
// ipcidr_dp: cursor/remaining-count registers, block size pick, result register.
// Depends on ipcidr_pkg.
module ipcidr_dp
	import ipcidr_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic         clk,
	input  range_req_t   range_req,
	output block_req_t   block_rsp,
	input  ipcidr_cmd_t  cmd,
	output ipcidr_stat_t stat
);

	localparam int unsigned W = ADDR_BITS;
	localparam logic [W:0] TOP_BIT = {1'b1, {W{1'b0}}};

	logic [W:0]  cur_q;
	logic [W:0]  rem_q;
	logic        err_q;
	block_req_t  out_q;

	logic [W-1:0]      lo;
	logic [W-1:0]      hi;
	logic [W:0]        diff;
	logic [W-1:0]      cur_w;
	logic [W-1:0]      low_w;
	logic [W:0]        lowbit;
	logic [W:0]        smear;
	logic [W:0]        msbhot;
	logic [W:0]        size;
	logic [PLEN_W-1:0] k_bin;
	block_req_t        res;

	assign lo   = range_req.range_start[W-1:0];
	assign hi   = range_req.range_end[W-1:0];
	assign diff = {1'b0, hi} - {1'b0, lo};

	// largest aligned block at cur: lowest set bit (all of space when cur is 0)
	assign cur_w  = cur_q[W-1:0];
	assign low_w  = cur_w & (~cur_w + {{(W-1){1'b0}}, 1'b1});
	assign lowbit = (cur_w == '0) ? TOP_BIT : {1'b0, low_w};

	// largest power of two not above the remaining count
	always_comb begin
		smear = rem_q;
		for (int s = 1; s < W + 1; s = s * 2) begin
			smear = smear | (smear >> s);
		end
		msbhot = smear ^ (smear >> 1);
	end

	assign size = ((lowbit & smear) != '0) ? lowbit : msbhot;

	always_comb begin
		k_bin = '0;
		for (int i = 0; i <= W; i++) begin
			if (size[i]) begin
				k_bin = k_bin | PLEN_W'(i);
			end
		end
	end

	assign stat.last = err_q || (size == rem_q);

	always_comb begin
		if (err_q) begin
			res.block_base       = '0;
			res.block_prefix_len = '0;
			res.is_last          = 1'b1;
			res.range_error      = 1'b1;
		end else begin
			res.block_base       = FIELD_W'(cur_w);
			res.block_prefix_len = PLEN_W'(W) - k_bin;
			res.is_last          = stat.last;
			res.range_error      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= {1'b0, lo};
			err_q <= diff[W];
			rem_q <= diff + {{W{1'b0}}, 1'b1};
		end else if (cmd.emit) begin
			cur_q <= cur_q + size;
			rem_q <= rem_q - size;
			out_q <= res;
		end
	end

	assign block_rsp = out_q;

endmodule

>>> hdl/ip_range_to_cidr_blocks_unit.sv
`timescale 1ns / 1ps
// ip_range_to_cidr_blocks_unit: top level, splits an address range into CIDR blocks.
// Depends on ipcidr_pkg, ipcidr_ctrl and ipcidr_dp.
//
//   channel | signals                              | direction | request type
//   range   | range_valid, range_ready, range_req  | in        | range_req_t
//   block   | block_valid, block_ready, block_rsp  | out       | block_req_t
//
// One range request is taken in the cycle it arrives while the block is idle;
// the start/end difference and the order check are done at that edge.
// After that one block is produced per cycle while the output register is not stalled
// (one step of the size-pick loop in ipcidr_dp), and range_ready stays low until the
// last block of the range is produced: at most 2*ADDR_BITS-2 blocks.
// A start above end gives a single error result.
// A stalled output register (block_ready low) simply freezes the loop.
// Reset clears the sequencer and output valid; data registers are not reset.
module ip_range_to_cidr_blocks_unit
	import ipcidr_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       range_valid,
	output logic       range_ready,
	input  range_req_t range_req,
	output logic       block_valid,
	input  logic       block_ready,
	output block_req_t block_rsp
);

	ipcidr_cmd_t  cmd;
	ipcidr_stat_t stat;

	// sequencer: owns idle/run state and the output valid flag
	ipcidr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.range_valid (range_valid),
		.range_ready (range_ready),
		.block_valid (block_valid),
		.block_ready (block_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	// datapath: cursor, remaining count, block pick and result register
	ipcidr_dp #(
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.range_req (range_req),
		.block_rsp (block_rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

>>> hdl/ipcidr_chk.sv
`timescale 1ns / 1ps
// ipcidr_chk: port-level checks for ip_range_to_cidr_blocks_unit, bound to it.
// Depends on ipcidr_pkg.
module ipcidr_chk
	import ipcidr_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	input logic       range_valid,
	input logic       range_ready,
	input range_req_t range_req,
	input logic       block_valid,
	input logic       block_ready,
	input block_req_t block_rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		range_valid && !range_ready |=> range_valid && $stable(range_req))
		else $error("range request dropped or changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && !block_ready |=> block_valid && $stable(block_rsp))
		else $error("result dropped or changed while stalled");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && block_rsp.range_error |->
			block_rsp.is_last && block_rsp.block_base == '0 &&
			block_rsp.block_prefix_len == '0)
		else $error("malformed error result");

	a_plen_range: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid |-> block_rsp.block_prefix_len <= PLEN_W'(ADDR_BITS))
		else $error("prefix length beyond address width");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		range_valid && range_ready |=> !range_ready)
		else $error("new range taken before blocks were produced");

endmodule

bind ip_range_to_cidr_blocks_unit ipcidr_chk #(
	.ADDR_BITS (ADDR_BITS)
) u_ipcidr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.range_valid (range_valid),
	.range_ready (range_ready),
	.range_req   (range_req),
	.block_valid (block_valid),
	.block_ready (block_ready),
	.block_rsp   (block_rsp)
);

>>> bench/ip_range_to_cidr_blocks_unit_tb.sv
`timescale 1ns / 1ps
// ip_range_to_cidr_blocks_unit_tb: self-checking bench for the range-to-CIDR splitter.
// Depends on ipcidr_pkg and ip_range_to_cidr_blocks_unit; predicts every block
// request from each accepted range request and checks them in order.
module ip_range_to_cidr_blocks_unit_tb;
	import ipcidr_pkg::*;

	localparam int unsigned ADDR_W          = 32;
	localparam int unsigned RANDOM_RANGES   = 218;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	// worst legal run: ~250 requests x 62 blocks with receiver stalls on each,
	// plus sender gaps and the long hold-off, taken several times over
	localparam int unsigned CYCLE_LIMIT     = 600000;
	localparam int unsigned DRAIN_CYCLES    = 80;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_BURSTY
	} rx_mode_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       range_valid = 1'b0;
	logic       range_ready;
	range_req_t range_req   = '0;
	logic       block_valid;
	logic       block_ready = 1'b0;
	block_req_t block_rsp;

	block_req_t  expected_blocks[$];
	int unsigned fail_count    = 0;
	int unsigned cycle_count   = 0;
	bit          sender_gaps_on = 1'b0;
	int unsigned burst_left    = 0;
	bit          hold_off_req  = 1'b0;

	ip_range_to_cidr_blocks_unit #(
		.ADDR_BITS(ADDR_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.range_valid(range_valid),
		.range_ready(range_ready),
		.range_req  (range_req),
		.block_valid(block_valid),
		.block_ready(block_ready),
		.block_rsp  (block_rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ip_range_to_cidr_blocks_unit: mismatch");
		$finish;
	end

	// Greedy split: at each address place the largest aligned block that
	// does not run past the end. Start above end gives one error result.
	function automatic void predict_blocks(input logic [31:0] first_addr,
			input logic [31:0] last_addr);
		longint unsigned addr_mask;
		longint unsigned cur;
		longint unsigned hi;
		int unsigned     k;
		int unsigned     n;
		block_req_t      blk;
		addr_mask = (64'd1 << ADDR_W) - 1;
		cur       = first_addr & addr_mask;
		hi        = last_addr & addr_mask;
		n         = 0;
		if (cur > hi) begin
			blk = '{block_base: '0, block_prefix_len: '0, is_last: 1'b1, range_error: 1'b1};
			expected_blocks.insert(expected_blocks.size(), blk);
			return;
		end
		while (cur <= hi && n < 2 * ADDR_W) begin
			k = 0;
			while (k < ADDR_W && ((cur >> k) & 64'd1) == 0
					&& cur + (64'd2 << k) - 1 <= hi)
				k++;
			blk.block_base       = cur[31:0];
			blk.block_prefix_len = PLEN_W'(ADDR_W - k);
			blk.is_last          = 1'b0;
			blk.range_error      = 1'b0;
			expected_blocks.insert(expected_blocks.size(), blk);
			n++;
			cur += 64'd1 << k;
		end
		expected_blocks[$].is_last = 1'b1;
	endfunction

	// Offer one range request and hold it until taken. Valid is only dropped
	// when a gap follows, so back-to-back requests keep it high.
	task automatic send_range(input logic [31:0] first_addr, input logic [31:0] last_addr);
		int unsigned gap;
		range_valid <= 1'b1;
		range_req   <= '{range_start: first_addr, range_end: last_addr};
		do
			@(posedge clk);
		while (!range_ready);
		predict_blocks(first_addr, last_addr);
		if (sender_gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 10);
				gap        = $urandom_range(1, 12);
				range_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Receiver: switches between steady, coin-flip and bursty stalling;
	// a hold-off request parks ready low for a long counted stretch.
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned stall_left;
		mode       = RX_STEADY;
		mode_left  = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				block_ready <= 1'b0;
				for (int unsigned c = 0; c < HOLD_OFF_CYCLES; c++)
					@(posedge clk);
				block_ready <= 1'b1;
				continue;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(40, 160);
			end
			mode_left--;
			case (mode)
				RX_STEADY: begin
					block_ready <= 1'b1;
				end
				RX_COIN: begin
					block_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						block_ready <= 1'b0;
					end else if ($urandom_range(0, 5) == 0) begin
						stall_left = $urandom_range(0, 3);
						block_ready <= 1'b0;
					end else begin
						block_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Compare every accepted block request with the oldest prediction.
	always @(posedge clk) begin
		block_req_t want;
		if (arst_n && block_valid && block_ready) begin
			if (expected_blocks.size() == 0) begin
				$error("unexpected block request: base %h len %0d last %b err %b",
					block_rsp.block_base, block_rsp.block_prefix_len,
					block_rsp.is_last, block_rsp.range_error);
				fail_count++;
			end else begin
				want = expected_blocks.pop_front();
				if (block_rsp.block_base !== want.block_base) begin
					$error("block_base: expected %h, got %h",
						want.block_base, block_rsp.block_base);
					fail_count++;
				end
				if (block_rsp.block_prefix_len !== want.block_prefix_len) begin
					$error("block_prefix_len: expected %0d, got %0d",
						want.block_prefix_len, block_rsp.block_prefix_len);
					fail_count++;
				end
				if (block_rsp.is_last !== want.is_last) begin
					$error("is_last: expected %b, got %b", want.is_last, block_rsp.is_last);
					fail_count++;
				end
				if (block_rsp.range_error !== want.range_error) begin
					$error("range_error: expected %b, got %b",
						want.range_error, block_rsp.range_error);
					fail_count++;
				end
			end
		end
	end

	// /32 blocks at both ends of the space and in the middle
	task automatic test_single_addresses();
		send_range(32'h0000_0000, 32'h0000_0000);
		send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_range(32'h8000_0000, 32'h8000_0000);
	endtask

	// whole space gives a single /0; near-whole ranges split heavily
	task automatic test_whole_space();
		send_range(32'h0000_0000, 32'hFFFF_FFFF);
		send_range(32'h0000_0000, 32'hFFFF_FFFE);
		send_range(32'h0000_0001, 32'hFFFF_FFFF);
	endtask

	// longest split: both ends misaligned by one; then a pair straddling the midpoint
	task automatic test_worst_case();
		send_range(32'h0000_0001, 32'hFFFF_FFFE);
		send_range(32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	// start above end: one error result each
	task automatic test_reversed_ranges();
		send_range(32'h0000_0001, 32'h0000_0000);
		send_range(32'hFFFF_FFFF, 32'h0000_0000);
		send_range(32'h8000_0000, 32'h7FFF_FFFF);
		send_range(32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	// halves, typical aligned prefixes and a /24 trimmed by one at both ends
	task automatic test_aligned_blocks();
		send_range(32'h0000_0000, 32'h7FFF_FFFF);
		send_range(32'h8000_0000, 32'hFFFF_FFFF);
		send_range(32'h0A00_0000, 32'h0A00_00FF);
		send_range(32'hC0A8_0100, 32'hC0A8_017F);
		send_range(32'h0A00_0001, 32'h0A00_00FE);
	endtask

	// alternating bit patterns so every address bit is driven both ways
	task automatic test_bit_patterns();
		send_range(32'h5555_5555, 32'hAAAA_AAAA);
		send_range(32'h3333_3333, 32'hCCCC_CCCC);
		send_range(32'h0F0F_0F0F, 32'hF0F0_F0F0);
	endtask

	// Mostly well-formed ranges with random content: small spans, exact
	// aligned blocks (sometimes nudged off by one), wide spans, and a few
	// reversed ones. The first stretch runs without sender gaps.
	task automatic test_random_ranges();
		logic [31:0]     first_addr;
		logic [31:0]     last_addr;
		logic [31:0]     tmp;
		longint unsigned span;
		int unsigned     plen;
		for (int unsigned i = 0; i < RANDOM_RANGES; i++) begin
			sender_gaps_on = (i >= 40);
			case ($urandom_range(0, 9))
				0: begin
					first_addr = $urandom_range(1, 32'hFFFF_FFFF);
					last_addr  = $urandom_range(0, first_addr - 1);
				end
				1, 2: begin
					first_addr = $urandom;
					last_addr  = first_addr + $urandom_range(0, 300);
					if (last_addr < first_addr)
						last_addr = 32'hFFFF_FFFF;
				end
				3, 4, 5: begin
					plen       = $urandom_range(0, ADDR_W);
					span       = 64'd1 << (ADDR_W - plen);
					first_addr = 32'($urandom & ~(span - 1));
					last_addr  = 32'(first_addr + span - 1);
					case ($urandom_range(0, 3))
						0: if (span > 1) last_addr = last_addr - 1;
						1: if (span > 1) first_addr = first_addr + 1;
						default: ;
					endcase
				end
				default: begin
					first_addr = $urandom;
					last_addr  = $urandom;
					if (first_addr > last_addr) begin
						tmp        = first_addr;
						first_addr = last_addr;
						last_addr  = tmp;
					end
				end
			endcase
			send_range(first_addr, last_addr);
		end
	endtask

	// Receiver parks for a long stretch while requests keep coming
	// back to back, so the output register fills and range_ready drops.
	task automatic test_back_pressure();
		sender_gaps_on = 1'b0;
		hold_off_req   = 1'b1;
		for (int unsigned i = 0; i < 12; i++)
			send_range($urandom_range(0, 32'h0000_FFFF), 32'h0001_0000 + $urandom_range(0, 4095));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_addresses();
		test_whole_space();
		test_worst_case();
		test_reversed_ranges();
		test_aligned_blocks();
		test_bit_patterns();
		test_back_pressure();
		test_random_ranges();
		range_valid <= 1'b0;
		// drain, then wait out DRAIN_CYCLES to catch stray requests
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ip_range_to_cidr_blocks_unit: match");
		else
			$display("ip_range_to_cidr_blocks_unit: mismatch");
		$finish;
	end

endmodule

>>> sim.f
hdl/ipcidr_pkg.sv
hdl/ipcidr_ctrl.sv
hdl/ipcidr_dp.sv
hdl/ip_range_to_cidr_blocks_unit.sv
hdl/ipcidr_chk.sv
bench/ip_range_to_cidr_blocks_unit_tb.sv
